@@ hdl/lavm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Look-at view matrix package
// Shared constants and the payload types of the input and result channels.
// ----------------------------------------------------------------------------
package lavm_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;

    localparam logic [1:0] ROW_LAST = 2'd3;

    typedef struct packed {
        logic signed [DATA_W-1:0] look_x;
        logic signed [DATA_W-1:0] look_y;
        logic signed [DATA_W-1:0] look_z;
        logic signed [DATA_W-1:0] eye_x;
        logic signed [DATA_W-1:0] eye_y;
        logic signed [DATA_W-1:0] eye_z;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] col0;
        logic signed [DATA_W-1:0] col1;
        logic signed [DATA_W-1:0] col2;
        logic signed [DATA_W-1:0] col3;
        logic [1:0]               row_index;
        logic                     last_row;
    } t_out;

endpackage

@@ hdl/lavm_norm.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined vector normalizer
// Squares and sums the components, takes a digit-by-digit integer square root
// one bit per stage, then divides each component by the length one quotient
// bit per stage with round-to-nearest. A zero-length vector gives zero.
// ----------------------------------------------------------------------------
module lavm_norm #(
    parameter int VW        = 32,
    parameter int FRAC_BITS = lavm_pkg::FRAC_BITS,
    parameter int SIDE_W    = 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [2:0][VW-1:0]        i_vec,
    input  logic [SIDE_W-1:0]         i_side,
    output logic                      o_valid,
    output logic [2:0][FRAC_BITS+1:0] o_vec,
    output logic [SIDE_W-1:0]         o_side
);

    localparam int SW = 2 * VW;
    localparam int NS = VW;
    localparam int QW = FRAC_BITS + 1;
    localparam int NW = VW + QW;
    localparam int OW = FRAC_BITS + 2;

    // Stage A: magnitudes and signs.
    logic                r_a_v;
    logic [2:0][VW-1:0]  r_a_mag;
    logic [2:0]          r_a_neg;
    logic [SIDE_W-1:0]   r_a_side;
    logic [2:0][VW-1:0]  n_a_mag;
    logic [2:0]          n_a_neg;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_a_neg[c] = i_vec[c][VW-1];
            n_a_mag[c] = i_vec[c][VW-1] ? (~i_vec[c] + VW'(1)) : i_vec[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (i_en) begin
            r_a_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_mag  <= n_a_mag;
            r_a_neg  <= n_a_neg;
            r_a_side <= i_side;
        end
    end

    // Stage B: squares.
    logic                r_b_v;
    logic [2:0][SW-1:0]  r_b_sq;
    logic [2:0][VW-1:0]  r_b_mag;
    logic [2:0]          r_b_neg;
    logic [SIDE_W-1:0]   r_b_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (i_en) begin
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                r_b_sq[c] <= r_a_mag[c] * r_a_mag[c];
            end
            r_b_mag  <= r_a_mag;
            r_b_neg  <= r_a_neg;
            r_b_side <= r_a_side;
        end
    end

    // Stage C: sum of squares. Three squares of VW-bit magnitudes stay below 2^SW.
    logic                r_c_v;
    logic [SW-1:0]       r_c_s;
    logic [2:0][VW-1:0]  r_c_mag;
    logic [2:0]          r_c_neg;
    logic [SIDE_W-1:0]   r_c_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (i_en) begin
            r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_s    <= r_b_sq[0] + r_b_sq[1] + r_b_sq[2];
            r_c_mag  <= r_b_mag;
            r_c_neg  <= r_b_neg;
            r_c_side <= r_b_side;
        end
    end

    // Square root stages, one result bit each.
    logic                r_q_v    [NS];
    logic [VW+1:0]       r_q_rem  [NS];
    logic [VW-1:0]       r_q_root [NS];
    logic [SW-1:0]       r_q_s    [NS];
    logic [2:0][VW-1:0]  r_q_mag  [NS];
    logic [2:0]          r_q_neg  [NS];
    logic [SIDE_W-1:0]   r_q_side [NS];

    for (genvar j = 0; j < NS; j++) begin : g_sqrt
        logic               p_v;
        logic [VW+1:0]      p_rem;
        logic [VW-1:0]      p_root;
        logic [SW-1:0]      p_s;
        logic [2:0][VW-1:0] p_mag;
        logic [2:0]         p_neg;
        logic [SIDE_W-1:0]  p_side;
        logic [VW+1:0]      rem2;
        logic [VW+1:0]      trial;

        if (j == 0) begin : g_first
            assign p_v    = r_c_v;
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_s    = r_c_s;
            assign p_mag  = r_c_mag;
            assign p_neg  = r_c_neg;
            assign p_side = r_c_side;
        end else begin : g_next
            assign p_v    = r_q_v[j-1];
            assign p_rem  = r_q_rem[j-1];
            assign p_root = r_q_root[j-1];
            assign p_s    = r_q_s[j-1];
            assign p_mag  = r_q_mag[j-1];
            assign p_neg  = r_q_neg[j-1];
            assign p_side = r_q_side[j-1];
        end

        // The remainder entering this stage is below 2^VW, so its low bits suffice.
        assign rem2  = {p_rem[VW-1:0], p_s[SW-1:SW-2]};
        assign trial = {p_root, 2'b01};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_q_v[j] <= 1'b0;
            end else if (i_en) begin
                r_q_v[j] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (rem2 >= trial) begin
                    r_q_rem[j]  <= rem2 - trial;
                    r_q_root[j] <= {p_root[VW-2:0], 1'b1};
                end else begin
                    r_q_rem[j]  <= rem2;
                    r_q_root[j] <= {p_root[VW-2:0], 1'b0};
                end
                r_q_s[j]    <= {p_s[SW-3:0], 2'b00};
                r_q_mag[j]  <= p_mag;
                r_q_neg[j]  <= p_neg;
                r_q_side[j] <= p_side;
            end
        end
    end

    // Stage P: rounded dividends.
    logic                r_p_v;
    logic [VW-1:0]       r_p_len;
    logic [2:0][NW-1:0]  r_p_num;
    logic [2:0]          r_p_neg;
    logic [SIDE_W-1:0]   r_p_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
        end else if (i_en) begin
            r_p_v <= r_q_v[NS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                r_p_num[c] <= (NW'(r_q_mag[NS-1][c]) << FRAC_BITS)
                            + NW'(r_q_root[NS-1] >> 1);
            end
            r_p_len  <= r_q_root[NS-1];
            r_p_neg  <= r_q_neg[NS-1];
            r_p_side <= r_q_side[NS-1];
        end
    end

    // Division stages. The magnitude never exceeds the length, so the
    // quotient fits in FRAC_BITS + 1 bits.
    logic                r_d_v    [QW];
    logic [2:0][NW-1:0]  r_d_num  [QW];
    logic [2:0][QW-1:0]  r_d_q    [QW];
    logic [VW-1:0]       r_d_len  [QW];
    logic [2:0]          r_d_neg  [QW];
    logic [SIDE_W-1:0]   r_d_side [QW];

    for (genvar k = 0; k < QW; k++) begin : g_div
        logic               p_v;
        logic [2:0][NW-1:0] p_num;
        logic [2:0][QW-1:0] p_q;
        logic [VW-1:0]      p_len;
        logic [2:0]         p_neg;
        logic [SIDE_W-1:0]  p_side;
        logic [NW-1:0]      sh;

        if (k == 0) begin : g_first
            assign p_v    = r_p_v;
            assign p_num  = r_p_num;
            assign p_q    = '0;
            assign p_len  = r_p_len;
            assign p_neg  = r_p_neg;
            assign p_side = r_p_side;
        end else begin : g_next
            assign p_v    = r_d_v[k-1];
            assign p_num  = r_d_num[k-1];
            assign p_q    = r_d_q[k-1];
            assign p_len  = r_d_len[k-1];
            assign p_neg  = r_d_neg[k-1];
            assign p_side = r_d_side[k-1];
        end

        assign sh = NW'(p_len) << (QW - 1 - k);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d_v[k] <= 1'b0;
            end else if (i_en) begin
                r_d_v[k] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int c = 0; c < 3; c++) begin
                    if (p_num[c] >= sh) begin
                        r_d_num[k][c] <= p_num[c] - sh;
                        r_d_q[k][c]   <= {p_q[c][QW-2:0], 1'b1};
                    end else begin
                        r_d_num[k][c] <= p_num[c];
                        r_d_q[k][c]   <= {p_q[c][QW-2:0], 1'b0};
                    end
                end
                r_d_len[k]  <= p_len;
                r_d_neg[k]  <= p_neg;
                r_d_side[k] <= p_side;
            end
        end
    end

    // Final stage: restore the sign, force zero for a zero length.
    logic                r_f_v;
    logic [2:0][OW-1:0]  r_f_vec;
    logic [SIDE_W-1:0]   r_f_side;
    logic [2:0][OW-1:0]  n_f_vec;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (r_d_len[QW-1] == '0) begin
                n_f_vec[c] = '0;
            end else if (r_d_neg[QW-1][c]) begin
                n_f_vec[c] = ~OW'(r_d_q[QW-1][c]) + OW'(1);
            end else begin
                n_f_vec[c] = OW'(r_d_q[QW-1][c]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= 1'b0;
        end else if (i_en) begin
            r_f_v <= r_d_v[QW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f_vec  <= n_f_vec;
            r_f_side <= r_d_side[QW-1];
        end
    end

    assign o_valid = r_f_v;
    assign o_vec   = r_f_vec;
    assign o_side  = r_f_side;

endmodule

@@ hdl/lavm_cross.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined cross product
// Computes a x b at full precision, then scales back by FRAC_BITS with
// rounding half away from zero. Three register stages.
// ----------------------------------------------------------------------------
module lavm_cross #(
    parameter int CW        = 18,
    parameter int OW        = 19,
    parameter int FRAC_BITS = lavm_pkg::FRAC_BITS,
    parameter int SIDE_W    = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [2:0][CW-1:0] i_a,
    input  logic [2:0][CW-1:0] i_b,
    input  logic [SIDE_W-1:0]  i_side,
    output logic               o_valid,
    output logic [2:0][OW-1:0] o_vec,
    output logic [SIDE_W-1:0]  o_side
);

    localparam int PW = 2 * CW;
    localparam int DW = PW + 1;
    localparam logic [DW-1:0] HALF = DW'(1) << (FRAC_BITS - 1);

    logic                    r_p_v;
    logic signed [PW-1:0]    r_p [6];
    logic [SIDE_W-1:0]       r_p_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
        end else if (i_en) begin
            r_p_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p[0]   <= $signed(i_a[1]) * $signed(i_b[2]);
            r_p[1]   <= $signed(i_a[2]) * $signed(i_b[1]);
            r_p[2]   <= $signed(i_a[2]) * $signed(i_b[0]);
            r_p[3]   <= $signed(i_a[0]) * $signed(i_b[2]);
            r_p[4]   <= $signed(i_a[0]) * $signed(i_b[1]);
            r_p[5]   <= $signed(i_a[1]) * $signed(i_b[0]);
            r_p_side <= i_side;
        end
    end

    logic                    r_s_v;
    logic [2:0][DW-1:0]      r_s;
    logic [SIDE_W-1:0]       r_s_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_v <= 1'b0;
        end else if (i_en) begin
            r_s_v <= r_p_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                r_s[c] <= {r_p[2*c][PW-1], r_p[2*c]} - {r_p[2*c+1][PW-1], r_p[2*c+1]};
            end
            r_s_side <= r_p_side;
        end
    end

    logic                    r_o_v;
    logic [2:0][OW-1:0]      r_o;
    logic [SIDE_W-1:0]       r_o_side;
    logic [2:0][DW-1:0]      rd_mag;
    logic [2:0][DW-1:0]      rd_m;
    logic [2:0][OW-1:0]      n_o;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            rd_mag[c] = r_s[c][DW-1] ? (~r_s[c] + DW'(1)) : r_s[c];
            rd_m[c]   = (rd_mag[c] + HALF) >> FRAC_BITS;
            n_o[c]    = r_s[c][DW-1] ? (~OW'(rd_m[c]) + OW'(1)) : OW'(rd_m[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (i_en) begin
            r_o_v <= r_s_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_o      <= n_o;
            r_o_side <= r_s_side;
        end
    end

    assign o_valid = r_o_v;
    assign o_vec   = r_o;
    assign o_side  = r_o_side;

endmodule

@@ hdl/look_at_view_matrix_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Look-at view matrix unit
// Builds the left-handed view matrix from a look direction and an eye
// position in signed fixed point and sends it out one row per transfer.
//
// Input channel: i_valid / o_stall carry one look vector and eye position
// per transfer. Result channel: o_valid / i_stall carry rows 0 to 3 in order;
// row 3 holds the translation and sets last_row.
// Coordinates are Q16.16 at the default FRAC_BITS of 16. Three square
// roots and three divisions are laid out as stages, one bit per stage.
// Matrices leave through the single result channel, which moves one row
// per transfer; the pipeline itself takes new items while earlier ones are
// in flight, in any cycle in which the row buffer frees up.
// Reset clears all valid bits and the row counter, not the data registers.
// When the receiver stalls, the output register and the row buffer hold;
// the whole pipeline freezes and o_stall is high while the buffer is full,
// except in the cycle in which the buffer sends its last row.
// ----------------------------------------------------------------------------
module look_at_view_matrix_unit #(
    parameter int FRAC_BITS = lavm_pkg::FRAC_BITS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  lavm_pkg::t_in   i_data,
    output logic            o_valid,
    input  logic            i_stall,
    output lavm_pkg::t_out  o_data
);

    localparam int DW    = lavm_pkg::DATA_W;
    localparam int VB    = FRAC_BITS + 2;
    localparam int VN    = FRAC_BITS + 3;
    localparam int PB    = VB + DW;
    localparam int SB    = PB + 2;
    localparam int SIDE1 = 3 * VB + 3 * DW;
    localparam int SIDE2 = 6 * VB + 3 * DW;

    localparam logic [VB-1:0] ONE_V     = VB'(1) << FRAC_BITS;
    localparam logic [VB-1:0] NEG_ONE_V = ~ONE_V + VB'(1);
    localparam logic [DW-1:0] ONE_FX    = DW'(1) << FRAC_BITS;
    localparam logic [SB-1:0] HALF      = SB'(1) << (FRAC_BITS - 1);
    localparam logic [SB-1:0] POS_LIM   = SB'(32'h7FFF_FFFF);
    localparam logic [SB-1:0] NEG_LIM   = SB'(33'h0_8000_0000);
    localparam logic [DW-1:0] SAT_MAX   = 32'h7FFF_FFFF;
    localparam logic [DW-1:0] SAT_MIN   = 32'h8000_0000;

    logic pipe_en;

    // Input register.
    logic              r_in_v;
    lavm_pkg::t_in     r_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (pipe_en) begin
            r_in_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_in <= i_data;
        end
    end

    // Normalize the look vector; the eye rides along.
    logic                n1_v;
    logic [2:0][VB-1:0]  n1_look;
    logic [3*DW-1:0]     n1_eye;

    lavm_norm #(
        .VW        (DW),
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    (3 * DW)
    ) u_norm_look (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (r_in_v),
        .i_vec   ({r_in.look_z, r_in.look_y, r_in.look_x}),
        .i_side  ({r_in.eye_z, r_in.eye_y, r_in.eye_x}),
        .o_valid (n1_v),
        .o_vec   (n1_look),
        .o_side  (n1_eye)
    );

    // Reference axis and first right vector. Crossing with a unit axis only
    // moves and negates components, so no multiplier is needed here.
    logic                r_rf_v;
    logic [2:0][VB-1:0]  r_rf_look;
    logic [2:0][VB-1:0]  r_rf_right;
    logic [3*DW-1:0]     r_rf_eye;
    logic                pole;
    logic [2:0][VB-1:0]  n_rf_right;

    assign pole = (n1_look[1] == ONE_V) || (n1_look[1] == NEG_ONE_V);

    always_comb begin
        if (pole) begin
            n_rf_right[0] = '0;
            n_rf_right[1] = ~n1_look[2] + VB'(1);
            n_rf_right[2] = n1_look[1];
        end else begin
            n_rf_right[0] = n1_look[2];
            n_rf_right[1] = '0;
            n_rf_right[2] = ~n1_look[0] + VB'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf_v <= 1'b0;
        end else if (pipe_en) begin
            r_rf_v <= n1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_rf_look  <= n1_look;
            r_rf_right <= n_rf_right;
            r_rf_eye   <= n1_eye;
        end
    end

    // up = normalize(look x right)
    logic                c1_v;
    logic [2:0][VN-1:0]  c1_vec;
    logic [SIDE1-1:0]    c1_side;

    lavm_cross #(
        .CW        (VB),
        .OW        (VN),
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    (SIDE1)
    ) u_cross_up (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (r_rf_v),
        .i_a     (r_rf_look),
        .i_b     (r_rf_right),
        .i_side  ({r_rf_look, r_rf_eye}),
        .o_valid (c1_v),
        .o_vec   (c1_vec),
        .o_side  (c1_side)
    );

    logic                n2_v;
    logic [2:0][VB-1:0]  n2_up;
    logic [SIDE1-1:0]    n2_side;
    logic [2:0][VB-1:0]  n2_look;
    logic [3*DW-1:0]     n2_eye;

    lavm_norm #(
        .VW        (VN),
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    (SIDE1)
    ) u_norm_up (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (c1_v),
        .i_vec   (c1_vec),
        .i_side  (c1_side),
        .o_valid (n2_v),
        .o_vec   (n2_up),
        .o_side  (n2_side)
    );

    assign {n2_look, n2_eye} = n2_side;

    // right = normalize(up x look)
    logic                c2_v;
    logic [2:0][VN-1:0]  c2_vec;
    logic [SIDE2-1:0]    c2_side;

    lavm_cross #(
        .CW        (VB),
        .OW        (VN),
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    (SIDE2)
    ) u_cross_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (n2_v),
        .i_a     (n2_up),
        .i_b     (n2_look),
        .i_side  ({n2_up, n2_look, n2_eye}),
        .o_valid (c2_v),
        .o_vec   (c2_vec),
        .o_side  (c2_side)
    );

    logic                n3_v;
    logic [2:0][VB-1:0]  n3_right;
    logic [SIDE2-1:0]    n3_side;
    logic [2:0][VB-1:0]  n3_up;
    logic [2:0][VB-1:0]  n3_look;
    logic [2:0][DW-1:0]  n3_eye;

    lavm_norm #(
        .VW        (VN),
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    (SIDE2)
    ) u_norm_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (c2_v),
        .i_vec   (c2_vec),
        .i_side  (c2_side),
        .o_valid (n3_v),
        .o_vec   (n3_right),
        .o_side  (n3_side)
    );

    assign {n3_up, n3_look, n3_eye} = n3_side;

    // Translation: rotation rows are indexed [vector][component], with
    // vector 0 = right, 1 = up, 2 = look.
    logic [2:0][2:0][VB-1:0] n3_rot;
    assign n3_rot = {n3_look, n3_up, n3_right};

    logic                    r_t1_v;
    logic signed [PB-1:0]    r_t1_p [3][3];
    logic [2:0][2:0][VB-1:0] r_t1_rot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1_v <= 1'b0;
        end else if (pipe_en) begin
            r_t1_v <= n3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            for (int v = 0; v < 3; v++) begin
                for (int c = 0; c < 3; c++) begin
                    r_t1_p[v][c] <= $signed(n3_rot[v][c]) * $signed(n3_eye[c]);
                end
            end
            r_t1_rot <= n3_rot;
        end
    end

    logic                    r_t2_v;
    logic [2:0][SB-1:0]      r_t2_s;
    logic [2:0][2:0][VB-1:0] r_t2_rot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t2_v <= 1'b0;
        end else if (pipe_en) begin
            r_t2_v <= r_t1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            for (int v = 0; v < 3; v++) begin
                r_t2_s[v] <= SB'(r_t1_p[v][0]) + SB'(r_t1_p[v][1]) + SB'(r_t1_p[v][2]);
            end
            r_t2_rot <= r_t1_rot;
        end
    end

    // Round, negate and saturate to 32 bits.
    logic                    r_t3_v;
    logic [2:0][DW-1:0]      r_t3_tr;
    logic [2:0][2:0][VB-1:0] r_t3_rot;
    logic [2:0][SB-1:0]      tr_mag;
    logic [2:0][SB-1:0]      tr_m;
    logic [2:0][DW-1:0]      n_t3_tr;

    always_comb begin
        for (int v = 0; v < 3; v++) begin
            tr_mag[v] = r_t2_s[v][SB-1] ? (~r_t2_s[v] + SB'(1)) : r_t2_s[v];
            tr_m[v]   = (tr_mag[v] + HALF) >> FRAC_BITS;
            if (r_t2_s[v][SB-1]) begin
                n_t3_tr[v] = (tr_m[v] > POS_LIM) ? SAT_MAX : DW'(tr_m[v]);
            end else begin
                n_t3_tr[v] = (tr_m[v] > NEG_LIM) ? SAT_MIN : DW'(~tr_m[v] + SB'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t3_v <= 1'b0;
        end else if (pipe_en) begin
            r_t3_v <= r_t2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_t3_tr  <= n_t3_tr;
            r_t3_rot <= r_t2_rot;
        end
    end

    // Matrix buffer and row sequencer.
    logic                    r_mat_v;
    logic [1:0]              r_row;
    logic [2:0][2:0][VB-1:0] r_mat_rot;
    logic [2:0][DW-1:0]      r_mat_tr;
    logic                    r_out_v;
    lavm_pkg::t_out          r_out;
    lavm_pkg::t_out          n_out;
    logic                    out_free;
    logic                    emit;
    logic                    last_emit;

    assign out_free  = !r_out_v || !i_stall;
    assign emit      = r_mat_v && out_free;
    assign last_emit = emit && (r_row == lavm_pkg::ROW_LAST);
    assign pipe_en   = !r_mat_v || last_emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mat_v <= 1'b0;
            r_row   <= '0;
        end else if (pipe_en) begin
            r_mat_v <= r_t3_v;
            r_row   <= '0;
        end else if (emit) begin
            r_row <= r_row + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_mat_rot <= r_t3_rot;
            r_mat_tr  <= r_t3_tr;
        end
    end

    always_comb begin
        n_out.row_index = r_row;
        n_out.last_row  = (r_row == lavm_pkg::ROW_LAST);
        if (r_row == lavm_pkg::ROW_LAST) begin
            n_out.col0 = r_mat_tr[0];
            n_out.col1 = r_mat_tr[1];
            n_out.col2 = r_mat_tr[2];
            n_out.col3 = ONE_FX;
        end else begin
            n_out.col0 = {{(DW-VB){r_mat_rot[0][r_row][VB-1]}}, r_mat_rot[0][r_row]};
            n_out.col1 = {{(DW-VB){r_mat_rot[1][r_row][VB-1]}}, r_mat_rot[1][r_row]};
            n_out.col2 = {{(DW-VB){r_mat_rot[2][r_row][VB-1]}}, r_mat_rot[2][r_row]};
            n_out.col3 = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (out_free) begin
            r_out_v <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= n_out;
        end
    end

    assign o_stall = !pipe_en;
    assign o_valid = r_out_v;
    assign o_data  = r_out;

`ifndef NO_ASSERTIONS
    a_last_row_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.last_row == (o_data.row_index == lavm_pkg::ROW_LAST)))
        else $error("last_row does not match row_index");

    a_row_sequence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && (o_data.row_index != lavm_pkg::ROW_LAST)) |=>
        (o_valid && (o_data.row_index == $past(o_data.row_index) + 2'd1)))
        else $error("rows of one matrix are not sent back to back in order");

    a_rot_col3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_data.row_index != lavm_pkg::ROW_LAST)) |-> (o_data.col3 == '0))
        else $error("rotation row carries a nonzero fourth element");

    a_rot_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_data.row_index != lavm_pkg::ROW_LAST)) |->
        ($signed(o_data.col0) <= $signed(ONE_FX) && $signed(o_data.col0) >= -$signed(ONE_FX)
         && $signed(o_data.col2) <= $signed(ONE_FX)
         && $signed(o_data.col2) >= -$signed(ONE_FX)))
        else $error("normalized component exceeds one");

    a_stall_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mat_v && i_stall && r_out_v) |-> o_stall)
        else $error("input taken while the row buffer cannot drain");
`endif

endmodule

@@ tb/sv/look_at_view_matrix_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Look-at view matrix unit testbench
// Drives look vectors and eye positions through the valid/stall input
// channel and checks every matrix row against a fixed-point predictor of the
// left-handed look-at construction, or typed-in rows in three directed cases.
// Both sides idle at random; one long receiver hold-off fills the pipeline.
// ----------------------------------------------------------------------------
module look_at_view_matrix_unit_tb;

    localparam int          LATENCY    = 5 * lavm_pkg::FRAC_BITS + 69;
    localparam int          WATCHDOG   = 20000;
    localparam int          N_RANDOM   = 350;
    localparam int          N_DIRECTED = 18;
    localparam logic [63:0] ONE        = 64'd1 << lavm_pkg::FRAC_BITS;
    localparam logic [31:0] MAX32      = 32'h7fff_ffff;
    localparam logic [31:0] MIN32      = 32'h8000_0000;

    typedef logic signed [63:0] t_wide;

    // One directed stimulus row; rows with expectations typed in carry them.
    typedef struct {
        lavm_pkg::t_in  item;
        bit             known;
        lavm_pkg::t_out rows [4];
    } t_case;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_valid;
    logic            o_stall;
    lavm_pkg::t_in   i_data;
    logic            o_valid;
    logic            i_stall;
    lavm_pkg::t_out  o_data;

    lavm_pkg::t_out  pending_rows [$];
    int              errors;
    int              idle_cycles;
    bit              hold_off;
    t_case           cases [N_DIRECTED];

    look_at_view_matrix_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_wide round_q(t_wide v);
        t_wide m;
        m = (v < 0) ? -v : v;
        m = (m + (t_wide'(1) << (lavm_pkg::FRAC_BITS - 1))) >>> lavm_pkg::FRAC_BITS;
        return (v < 0) ? -m : m;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] s);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > s) b = b >> 2;
        while (b != 0) begin
            if (s >= res + b) begin
                s = s - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Magnitudes stay within 2^31, so the square sum fits 64 unsigned bits.
    task automatic unit_vec(input t_wide v [3], output t_wide o [3]);
        logic [63:0] s;
        logic [63:0] len;
        logic [63:0] m;
        logic [63:0] q;
        s = 0;
        for (int i = 0; i < 3; i++) begin
            m = (v[i] < 0) ? -v[i] : v[i];
            s = s + m * m;
        end
        len = int_sqrt(s);
        for (int i = 0; i < 3; i++) begin
            m = (v[i] < 0) ? -v[i] : v[i];
            if (len == 0) begin
                o[i] = 0;
            end else begin
                q = ((m << lavm_pkg::FRAC_BITS) + (len >> 1)) / len;
                o[i] = (v[i] < 0) ? -t_wide'(q) : t_wide'(q);
            end
        end
    endtask

    task automatic cross_q(input t_wide a [3], input t_wide b [3], output t_wide o [3]);
        o[0] = round_q(a[1] * b[2] - a[2] * b[1]);
        o[1] = round_q(a[2] * b[0] - a[0] * b[2]);
        o[2] = round_q(a[0] * b[1] - a[1] * b[0]);
    endtask

    function automatic logic [31:0] neg_dot(t_wide a [3], t_wide e [3]);
        t_wide d;
        d = -round_q(a[0] * e[0] + a[1] * e[1] + a[2] * e[2]);
        if (d > t_wide'($signed(MAX32))) return MAX32;
        if (d < t_wide'($signed(MIN32))) return MIN32;
        return d[31:0];
    endfunction

    task automatic predict_view_rows(input lavm_pkg::t_in it, output lavm_pkg::t_out rows [4]);
        t_wide raw [3];
        t_wide eye [3];
        t_wide fwd [3];
        t_wide ref_axis [3];
        t_wide side [3];
        t_wide upv [3];
        t_wide tmp [3];
        raw[0] = it.look_x; raw[1] = it.look_y; raw[2] = it.look_z;
        eye[0] = it.eye_x;  eye[1] = it.eye_y;  eye[2] = it.eye_z;
        unit_vec(raw, fwd);
        ref_axis[0] = 0; ref_axis[1] = ONE; ref_axis[2] = 0;
        // Looking straight up or down: fall back to world X.
        if (fwd[1] == t_wide'(ONE) || fwd[1] == -t_wide'(ONE)) begin
            ref_axis[0] = ONE;
            ref_axis[1] = 0;
        end
        cross_q(ref_axis, fwd, side);
        cross_q(fwd, side, tmp);
        unit_vec(tmp, upv);
        cross_q(upv, fwd, tmp);
        unit_vec(tmp, side);
        for (int k = 0; k < 3; k++) begin
            rows[k].col0 = side[k][31:0];
            rows[k].col1 = upv[k][31:0];
            rows[k].col2 = fwd[k][31:0];
            rows[k].col3 = '0;
            rows[k].row_index = k[1:0];
            rows[k].last_row = 1'b0;
        end
        rows[3].col0 = neg_dot(side, eye);
        rows[3].col1 = neg_dot(upv, eye);
        rows[3].col2 = neg_dot(fwd, eye);
        rows[3].col3 = ONE[31:0];
        rows[3].row_index = lavm_pkg::ROW_LAST;
        rows[3].last_row = 1'b1;
    endtask

    function automatic lavm_pkg::t_in make_item(logic [31:0] lx, logic [31:0] ly,
                                                logic [31:0] lz, logic [31:0] ex,
                                                logic [31:0] ey, logic [31:0] ez);
        lavm_pkg::t_in it;
        it.look_x = lx; it.look_y = ly; it.look_z = lz;
        it.eye_x = ex;  it.eye_y = ey;  it.eye_z = ez;
        return it;
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return $urandom_range(0, 8) << 16;
            2:       return -($urandom_range(0, 8) << 16);
            3:       return $urandom_range(0, 3) == 0 ? MIN32 : MAX32;
            4:       return $urandom_range(0, 1) ? $urandom_range(0, 3) : -$urandom_range(0, 3);
            default: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
        endcase
    endfunction

    function automatic lavm_pkg::t_in rand_item();
        lavm_pkg::t_in it;
        it = make_item(rand_coord(), rand_coord(), rand_coord(),
                       rand_coord(), rand_coord(), rand_coord());
        // Some look vectors lie on the Y axis to reach the world X fallback.
        if ($urandom_range(0, 9) == 0) begin
            it.look_x = 0;
            it.look_z = 0;
        end
        return it;
    endfunction

    task automatic set_known(int n, lavm_pkg::t_out r0, lavm_pkg::t_out r1,
                             lavm_pkg::t_out r2, lavm_pkg::t_out r3);
        cases[n].known = 1'b1;
        cases[n].rows[0] = r0;
        cases[n].rows[1] = r1;
        cases[n].rows[2] = r2;
        cases[n].rows[3] = r3;
    endtask

    task automatic build_cases();
        logic [31:0] o;
        o = ONE[31:0];
        for (int n = 0; n < N_DIRECTED; n++) cases[n].known = 1'b0;
        // Zero look vector: zero rotation and translation, (3,3) stays one.
        cases[0].item = make_item(0, 0, 0, o, o, o);
        set_known(0, '{0, 0, 0, 0, 2'd0, 1'b0}, '{0, 0, 0, 0, 2'd1, 1'b0},
                  '{0, 0, 0, 0, 2'd2, 1'b0}, '{0, 0, 0, o, lavm_pkg::ROW_LAST, 1'b1});
        // Look along +Z: identity rotation, translation is minus the eye.
        cases[1].item = make_item(0, 0, o, 2 * o, 3 * o, 4 * o);
        set_known(1, '{o, 0, 0, 0, 2'd0, 1'b0}, '{0, o, 0, 0, 2'd1, 1'b0},
                  '{0, 0, o, 0, 2'd2, 1'b0},
                  '{-2 * o, -3 * o, -4 * o, o, lavm_pkg::ROW_LAST, 1'b1});
        // Large eye with identity rotation: translation saturates.
        cases[2].item = make_item(0, 0, MAX32, MIN32, MAX32, MIN32);
        set_known(2, '{o, 0, 0, 0, 2'd0, 1'b0}, '{0, o, 0, 0, 2'd1, 1'b0},
                  '{0, 0, o, 0, 2'd2, 1'b0},
                  '{MAX32, -MAX32, MAX32, o, lavm_pkg::ROW_LAST, 1'b1});
        cases[3].item = make_item(0, o, 0, o, 0, 0);
        cases[4].item = make_item(0, MIN32, 0, MAX32, MIN32, 0);
        cases[5].item = make_item(0, 5, 0, 0, 0, o);
        cases[6].item = make_item(MIN32, MIN32, MIN32, MIN32, MIN32, MIN32);
        cases[7].item = make_item(MAX32, MAX32, MAX32, MAX32, MAX32, MAX32);
        cases[8].item = make_item(1, 0, 0, 0, 0, 0);
        cases[9].item = make_item(-1, -1, -1, -1, -1, -1);
        cases[10].item = make_item(o, o, 0, 7 * o, -5 * o, 3 * o);
        cases[11].item = make_item(0, o, 1, 0, 0, 0);
        cases[12].item = make_item(MAX32, 1, MIN32, 32'h5555_5555, 32'haaaa_aaaa, 0);
        cases[13].item = make_item(-o, 0, 0, 0, MAX32, 0);
        cases[14].item = make_item(0, 0, -o, MIN32, 0, MAX32);
        cases[15].item = make_item(3 * o, -4 * o, 12 * o, o, -o, o);
        cases[16].item = make_item(32'haaaa_aaaa, 32'h5555_5555, 32'hffff_0000,
                                   32'h0000_ffff, 32'h1234_5678, 32'hedcb_a988);
        cases[17].item = make_item(MAX32, 0, 0, MAX32, 0, 0);
    endtask

    // Sends one transfer, holding the payload while the block stalls.
    task automatic send_item(input lavm_pkg::t_in it);
        i_valid <= 1'b1;
        i_data  <= it;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic queue_rows(input lavm_pkg::t_out rows [4]);
        for (int k = 0; k < 4; k++) pending_rows.push_back(rows[k]);
    endtask

    task automatic feed_items();
        lavm_pkg::t_out rows [4];
        lavm_pkg::t_out model_rows [4];
        lavm_pkg::t_in  it;
        int             burst;
        burst = 0;
        for (int n = 0; n < N_DIRECTED + N_RANDOM; n++) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 12);
                if ($urandom_range(0, 2) != 0) begin
                    i_valid <= 1'b0;
                    repeat ($urandom_range(1, 10)) @(posedge i_clk);
                end
            end
            burst--;
            if (n < N_DIRECTED) begin
                predict_view_rows(cases[n].item, model_rows);
                if (cases[n].known) begin
                    rows = cases[n].rows;
                end else begin
                    rows = model_rows;
                end
                queue_rows(rows);
                send_item(cases[n].item);
            end else begin
                it = rand_item();
                predict_view_rows(it, rows);
                queue_rows(rows);
                send_item(it);
            end
        end
        i_valid <= 1'b0;
    endtask

    // Receiver stall pattern, with one long hold-off partway through.
    initial begin
        int phase;
        phase = 0;
        hold_off = 1'b0;
        i_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            phase++;
            if (phase == 300) begin
                hold_off = 1'b1;
                i_stall <= 1'b1;
                repeat (600) @(posedge i_clk);
                hold_off = 1'b0;
            end
            if (phase % 97 < 30) i_stall <= 1'b0;
            else i_stall <= ($urandom_range(0, 3) == 0);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_rows.size() == 0) begin
                $display("%0t: row with no expectation: %p", $realtime, o_data);
                errors++;
            end else begin
                lavm_pkg::t_out want;
                want = pending_rows.pop_front();
                if (want.col0 !== o_data.col0 || want.col1 !== o_data.col1
                    || want.col2 !== o_data.col2 || want.col3 !== o_data.col3
                    || want.row_index !== o_data.row_index
                    || want.last_row !== o_data.last_row) begin
                    $display("%0t: row mismatch: expected %p, actual %p",
                             $realtime, want, o_data);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no transfer on either channel.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || hold_off || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        errors = 0;
        idle_cycles = 0;
        build_cases();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        feed_items();
        while (pending_rows.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (errors == 0 && pending_rows.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
